// ===== hdl/fpli_pkg.sv =====
// Shared types, constants and fixed-point helpers for the five-point
// Lagrange interpolator. No dependencies.
package fpli_pkg;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic {
    REG_STEP_INVERSE = 1'b0,
    REG_MAX_INDEX    = 1'b1
  } reg_index_t;

  localparam logic [23:0] STEP_INVERSE_RESET = 24'd655360;
  localparam logic [11:0] MAX_INDEX_RESET    = 12'd4092;

  localparam int FRONT_QUEUE_DEPTH  = 4;
  localparam int RESULT_QUEUE_DEPTH = 16;

  // 1/24 in Q0.24
  localparam logic signed [20:0] RECIP_24 = 21'sd699051;
  localparam logic signed [65:0] W_MAX = 66'sd34359738367;
  localparam logic signed [65:0] W_MIN = -66'sd34359738368;

  typedef struct packed {
    logic [23:0] step_inverse;
    logic [11:0] max_index;
  } cfg_t;

  typedef struct packed {
    logic               is_query;
    logic signed [27:0] p;
    logic signed [31:0] sample_real;
    logic signed [31:0] sample_imag;
    logic               last;
  } entry_t;

  typedef struct packed {
    logic signed [31:0] value_real;
    logic signed [31:0] value_imag;
    logic               last;
  } result_t;

  // Saturate to Q12.24.
  function automatic logic signed [35:0] wsat(input logic signed [65:0] x);
    if (x > W_MAX) begin
      return W_MAX[35:0];
    end
    if (x < W_MIN) begin
      return W_MIN[35:0];
    end
    return 36'(x);
  endfunction

  // Round a Q.48 product to Q.24 (half up), then saturate.
  function automatic logic signed [35:0] qround(input logic signed [65:0] x);
    logic signed [65:0] t;
    t = (x + 66'sd8388608) >>> 24;
    return wsat(t);
  endfunction

endpackage

// ===== hdl/fpli_queue.sv =====
// Small synchronous FIFO of packed words between pipeline sections.
// Depends on nothing; DEPTH must be a power of two.
module fpli_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign pop_data = slots[rd_ptr];
  assign empty    = (count == '0);
endmodule

// ===== hdl/fpli_front.sv =====
// Front section: accept words, drop out-of-range loads, scale the radius,
// pick the clamped centre index and the offset p. Uses fpli_pkg.
module fpli_front #(
  parameter int TABLE_DEPTH = 4096,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                mode,
  input  logic [11:0]                         load_index,
  input  logic signed [31:0]                  sample_real,
  input  logic signed [31:0]                  sample_imag,
  input  logic [31:0]                         query_r,
  input  logic                                last_query,
  input  fpli_pkg::cfg_t                      cfg,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count,
  output logic                                push,
  output logic [$clog2(TABLE_DEPTH)-1:0]      push_addr,
  output fpli_pkg::entry_t                    push_entry
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [24:0] LIMIT_TOP = 25'(TABLE_DEPTH - 4);
  localparam logic signed [57:0] P_MAX = 58'sd134217727;
  localparam logic signed [57:0] P_MIN = -58'sd134217728;

  logic               accept;
  logic               is_query;
  logic               load_ok;

  logic               a_valid;
  logic               a_query;
  logic [11:0]        a_index;
  logic signed [31:0] a_real;
  logic signed [31:0] a_imag;
  logic               a_last;
  logic [55:0]        a_prod;

  logic               b_valid;
  logic               b_query;
  logic [AW-1:0]      b_index;
  logic signed [31:0] b_real;
  logic signed [31:0] b_imag;
  logic               b_last;
  logic [55:0]        b_prod;

  logic [56:0]        rsum;
  logic [24:0]        near;
  logic [24:0]        limit;
  logic [24:0]        centre;
  logic signed [57:0] diff;
  logic signed [57:0] rounded;
  logic signed [27:0] p_sat;

  assign accept   = item_valid && !item_stall;
  assign is_query = (mode == fpli_pkg::MODE_QUERY);
  assign load_ok  = (32'(load_index) < 32'(TABLE_DEPTH));

  // Hold off the sender once words in flight could overrun the queue.
  assign item_stall = (int'(q_count) + int'(a_valid) + int'(b_valid)) >= QUEUE_DEPTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept && (is_query || load_ok);
      b_valid <= a_valid;
    end
  end

  // Nearest index, clamped to 2..min(max_index, depth-4).
  always_comb begin
    rsum   = {1'b0, a_prod} + (57'd1 << 31);
    near   = rsum[56:32];
    limit  = (25'(cfg.max_index) > LIMIT_TOP) ? LIMIT_TOP : 25'(cfg.max_index);
    centre = (near > limit) ? limit : near;
    if (centre < 25'd2) begin
      centre = 25'd2;
    end
  end

  always_ff @(posedge clk) begin
    a_query <= is_query;
    a_index <= load_index;
    a_real  <= sample_real;
    a_imag  <= sample_imag;
    a_last  <= last_query;
    a_prod  <= query_r * cfg.step_inverse;

    b_query <= a_query;
    b_index <= a_query ? AW'(centre) : AW'(a_index);
    b_real  <= a_real;
    b_imag  <= a_imag;
    b_last  <= a_last;
    b_prod  <= a_prod;
  end

  // Offset p = t - i, rounded to Q4.24 and saturated.
  always_comb begin
    diff    = $signed({2'b00, b_prod}) - $signed(58'({b_index, 32'd0}));
    rounded = (diff + 58'sd128) >>> 8;
    if (rounded > P_MAX) begin
      p_sat = P_MAX[27:0];
    end else if (rounded < P_MIN) begin
      p_sat = P_MIN[27:0];
    end else begin
      p_sat = 28'(rounded);
    end
  end

  assign push                   = b_valid;
  assign push_addr              = b_index;
  assign push_entry.is_query    = b_query;
  assign push_entry.p           = p_sat;
  assign push_entry.sample_real = b_real;
  assign push_entry.sample_imag = b_imag;
  assign push_entry.last        = b_last;
endmodule

// ===== hdl/fpli_back.sv =====
// Back section: Lagrange weights from p, five table lanes, weighted sums.
// Uses fpli_pkg; holds the sample tables.
module fpli_back #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              q_empty,
  input  logic [$clog2(TABLE_DEPTH)-1:0]                    q_addr,
  input  fpli_pkg::entry_t                                  q_entry,
  output logic                                              pop,
  input  logic [$clog2(fpli_pkg::RESULT_QUEUE_DEPTH+1)-1:0] out_count,
  output logic                                              push,
  output fpli_pkg::result_t                                 push_result
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NQ = 9;

  logic [NQ-1:0]    qv;
  logic [5:0]       lv;
  fpli_pkg::entry_t ent  [6];
  logic [AW-1:0]    addr [6];
  logic             last6;
  logic             last7;
  logic             last8;

  logic signed [35:0] p2;
  logic signed [35:0] x1a;
  logic signed [35:0] x1;
  logic signed [35:0] x2;
  logic signed [35:0] x3;
  logic signed [35:0] x4;
  logic signed [35:0] x2_5;
  logic signed [35:0] x3_5;
  logic signed [35:0] x4_5;
  logic signed [35:0] x5;
  logic signed [36:0] coef [5];
  logic [63:0]        rd   [5];

  logic signed [55:0] m1;
  logic signed [36:0] p2m1;
  logic signed [64:0] m2;
  logic signed [56:0] m3;
  logic signed [63:0] m4;
  logic signed [63:0] m5;
  logic signed [28:0] hp;
  logic signed [35:0] x2n;
  logic signed [35:0] x4n;
  logic signed [35:0] d53;

  logic signed [44:0] phr [5];
  logic signed [44:0] phi [5];
  logic signed [56:0] plr [5];
  logic signed [56:0] pli [5];
  logic signed [47:0] hr;
  logic signed [47:0] hi;
  logic signed [59:0] lr;
  logic signed [59:0] li;
  logic signed [47:0] hr_n;
  logic signed [47:0] hi_n;
  logic signed [59:0] lr_n;
  logic signed [59:0] li_n;
  logic signed [48:0] tr;
  logic signed [48:0] ti;

  logic credit_ok;

  // Take a word only if its result is sure to find room downstream.
  assign credit_ok = (int'(out_count) + $countones(qv)) < fpli_pkg::RESULT_QUEUE_DEPTH;
  assign pop       = !q_empty && credit_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= '0;
      lv <= '0;
    end else begin
      qv <= {qv[NQ-2:0], pop && q_entry.is_query};
      lv <= {lv[4:0], pop && !q_entry.is_query};
    end
  end

  always_ff @(posedge clk) begin
    ent[0]  <= q_entry;
    addr[0] <= q_addr;
    for (int j = 1; j < 6; j++) begin
      ent[j]  <= ent[j-1];
      addr[j] <= addr[j-1];
    end
    last6 <= ent[5].last;
    last7 <= last6;
    last8 <= last7;
  end

  always_comb begin
    m1   = ent[0].p * ent[0].p;
    p2m1 = 37'(p2) - 37'sd16777216;
    m2   = ent[1].p * p2m1;
    m3   = x1a * fpli_pkg::RECIP_24;
    m4   = x1 * ent[3].p;
    m5   = x4 * ent[4].p;
    hp   = (29'(ent[3].p) + 29'sd1) >>> 1;
    x2n  = fpli_pkg::wsat(66'(x1) + 66'(x1));
    x4n  = fpli_pkg::wsat(66'(x2n) + 66'(x2n) - 66'(hp));
    d53  = fpli_pkg::wsat(66'(x5) - 66'(x3_5));
  end

  always_ff @(posedge clk) begin
    p2   <= fpli_pkg::qround(66'(m1));
    x1a  <= fpli_pkg::qround(66'(m2));
    x1   <= fpli_pkg::qround(66'(m3));
    x3   <= fpli_pkg::qround(66'(m4));
    x2   <= x2n;
    x4   <= x4n;
    x5   <= fpli_pkg::qround(66'(m5));
    x2_5 <= x2;
    x3_5 <= x3;
    x4_5 <= x4;
    coef[0] <= 37'(fpli_pkg::wsat(66'(x3_5) - 66'(x2_5)));
    coef[1] <= -37'(fpli_pkg::wsat(66'(x5) - 66'(x4_5)));
    coef[2] <= 37'(fpli_pkg::wsat(66'(d53) + 66'(d53) + 66'sd16777216));
    coef[3] <= -37'(fpli_pkg::wsat(66'(x5) + 66'(x4_5)));
    coef[4] <= 37'(fpli_pkg::wsat(66'(x3_5) + 66'(x2_5)));
  end

  // One table copy per window tap; loads write every copy at the same
  // stage where queries read, so table order follows word order.
  for (genvar k = 0; k < 5; k++) begin : g_lane
    logic [63:0]   mem [TABLE_DEPTH];
    logic [AW-1:0] raddr;

    assign raddr = addr[5] + AW'(k) - AW'(1);

    always_ff @(posedge clk) begin
      if (lv[5]) begin
        mem[addr[5]] <= {ent[5].sample_real, ent[5].sample_imag};
      end
      rd[k] <= mem[raddr];
    end

    // Split each weight into its integer part and 24 fraction bits.
    always_ff @(posedge clk) begin
      phr[k] <= $signed(rd[k][63:32]) * $signed(coef[k][36:24]);
      phi[k] <= $signed(rd[k][31:0]) * $signed(coef[k][36:24]);
      plr[k] <= $signed(rd[k][63:32]) * $signed({1'b0, coef[k][23:0]});
      pli[k] <= $signed(rd[k][31:0]) * $signed({1'b0, coef[k][23:0]});
    end
  end

  always_comb begin
    hr_n = '0;
    hi_n = '0;
    lr_n = '0;
    li_n = '0;
    for (int k = 0; k < 5; k++) begin
      hr_n = hr_n + 48'(phr[k]);
      hi_n = hi_n + 48'(phi[k]);
      lr_n = lr_n + 60'(plr[k]);
      li_n = li_n + 60'(pli[k]);
    end
  end

  always_ff @(posedge clk) begin
    hr <= hr_n;
    hi <= hi_n;
    lr <= lr_n;
    li <= li_n;
  end

  always_comb begin
    tr = 49'(hr) + 49'((lr + 60'sd8388608) >>> 24);
    ti = 49'(hi) + 49'((li + 60'sd8388608) >>> 24);
    if (tr > 49'sd2147483647) begin
      push_result.value_real = 32'h7fffffff;
    end else if (tr < -49'sd2147483648) begin
      push_result.value_real = 32'h80000000;
    end else begin
      push_result.value_real = 32'(tr);
    end
    if (ti > 49'sd2147483647) begin
      push_result.value_imag = 32'h7fffffff;
    end else if (ti < -49'sd2147483648) begin
      push_result.value_imag = 32'h80000000;
    end else begin
      push_result.value_imag = 32'(ti);
    end
    push_result.last = last8;
  end

  assign push = qv[NQ-1];
endmodule

// ===== hdl/five_point_lagrange_interpolator_unit.sv =====
// Five-point Lagrange interpolator on a uniform grid, top level.
// Uses fpli_pkg, fpli_front, fpli_queue and fpli_back.
//
// Usage:
//   One input channel carries two kinds of word. A load word (mode 0)
//   writes one complex Q8.24 sample at load_index; loads beyond the table
//   are dropped and give no result. A query word (mode 1) brings a Q16.16
//   radius and returns one result: the five-point weighted sum of the real
//   and imaginary tables around the nearest grid index, saturated Q8.24,
//   with last_result copied from last_query. Results come out in order.
//   Tables are undefined until loaded; load every entry a query may touch.
//   Config (step_inverse, max_index) is written through cfg_write/cfg_index/
//   cfg_data, by the user only while no word is in flight (not enforced).
// Timing:
//   One word per cycle sustained while item_stall is low. A query goes from
//   acceptance to result_valid through two front stages (product, index and
//   offset), the queue, nine back stages (four chained multiplies for the
//   weights, the table read, lane products, sums), and the result queue.
//   The 16-entry result queue gives credit to the back section, so a stalled
//   receiver fills it and then backs up into the front queue and item_stall.
// Reset:
//   rst clears both queues, all stage valids and restores the config
//   registers; it does not touch the tables.
module five_point_lagrange_interpolator_unit #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               mode,
  input  logic [11:0]        load_index,
  input  logic signed [31:0] sample_real,
  input  logic signed [31:0] sample_imag,
  input  logic [31:0]        query_r,
  input  logic               last_query,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] value_real,
  output logic signed [31:0] value_imag,
  output logic               last_result,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FQ = fpli_pkg::FRONT_QUEUE_DEPTH;
  localparam int RQ = fpli_pkg::RESULT_QUEUE_DEPTH;
  localparam int FW = AW + $bits(fpli_pkg::entry_t);
  localparam int RW = $bits(fpli_pkg::result_t);

  fpli_pkg::cfg_t    cfg;
  logic              f_push;
  logic [AW-1:0]     f_addr;
  fpli_pkg::entry_t  f_entry;
  logic [FW-1:0]     fq_data;
  logic [$clog2(FQ+1)-1:0] fq_count;
  logic              fq_empty;
  logic [AW-1:0]     q_addr;
  fpli_pkg::entry_t  q_entry;
  logic              b_pop;
  logic              b_push;
  fpli_pkg::result_t b_result;
  logic [RW-1:0]     rq_data;
  logic [$clog2(RQ+1)-1:0] rq_count;
  logic              rq_empty;
  fpli_pkg::result_t head;
  logic              r_pop;

  // Config registers: writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_inverse <= fpli_pkg::STEP_INVERSE_RESET;
      cfg.max_index    <= fpli_pkg::MAX_INDEX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        fpli_pkg::REG_STEP_INVERSE: cfg.step_inverse <= cfg_data;
        fpli_pkg::REG_MAX_INDEX:    cfg.max_index    <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  fpli_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .QUEUE_DEPTH(FQ)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .mode       (mode),
    .load_index (load_index),
    .sample_real(sample_real),
    .sample_imag(sample_imag),
    .query_r    (query_r),
    .last_query (last_query),
    .cfg        (cfg),
    .q_count    (fq_count),
    .push       (f_push),
    .push_addr  (f_addr),
    .push_entry (f_entry)
  );

  // Decouple front and back: each side runs on its own count.
  fpli_queue #(
    .DEPTH(FQ),
    .WIDTH(FW)
  ) u_work_q (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .push_data({f_addr, f_entry}),
    .pop      (b_pop),
    .pop_data (fq_data),
    .count    (fq_count),
    .empty    (fq_empty)
  );

  assign {q_addr, q_entry} = fq_data;

  fpli_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (fq_empty),
    .q_addr     (q_addr),
    .q_entry    (q_entry),
    .pop        (b_pop),
    .out_count  (rq_count),
    .push       (b_push),
    .push_result(b_result)
  );

  // Result queue acts as the output register and skid buffer.
  fpli_queue #(
    .DEPTH(RQ),
    .WIDTH(RW)
  ) u_result_q (
    .clk      (clk),
    .rst      (rst),
    .push     (b_push),
    .push_data(b_result),
    .pop      (r_pop),
    .pop_data (rq_data),
    .count    (rq_count),
    .empty    (rq_empty)
  );

  assign head         = rq_data;
  assign result_valid = !rq_empty;
  assign r_pop        = result_valid && !result_stall;
  assign value_real   = head.value_real;
  assign value_imag   = head.value_imag;
  assign last_result  = head.last;
endmodule

// ===== hdl/fpli_checker.sv =====
// Port-level checks for the interpolator top level, bound to it below.
// Depends on five_point_lagrange_interpolator_unit ports only.
module fpli_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] value_real,
  input logic [31:0] value_imag,
  input logic        last_result
);
  // Reset empties every stage, so the block takes words right away.
  a_ready_after_reset: assert property (@(posedge clk) rst |=> !item_stall)
    else $error("item_stall high after reset");

  // No result can come out straight after reset, as reset empties the queues.
  a_no_early_result: assert property (
    @(posedge clk) rst |=> !result_valid ##1 !result_valid ##1 !result_valid)
    else $error("result appeared too soon after reset");

  // Hold a stalled result word.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(value_real) &&
      $stable(value_imag) && $stable(last_result))
    else $error("stalled result changed");
endmodule

bind five_point_lagrange_interpolator_unit fpli_checker u_fpli_checker (
  .clk         (clk),
  .rst         (rst),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .value_real  (value_real),
  .value_imag  (value_imag),
  .last_result (last_result)
);
